>>> hw/rtl/pcl_pkg.sv
// Shared types and constants for the positional byte list.
`default_nettype none
package pcl_pkg;
	localparam int DATA_W = 8;
	localparam int CNT_W  = 7;
	localparam int POS_W  = 6;
	localparam int REQ_W  = 3;

	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd6;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_INS,
		ACT_DEL,
		ACT_ROT
	} act_t;

	// broadcast to every cell; pos is the insert/delete point or the tail for rotate
	typedef struct packed {
		act_t              act;
		logic [CNT_W-1:0]  pos;
		logic [DATA_W-1:0] din;
	} cell_ctl_t;
endpackage
`default_nettype wire

>>> hw/rtl/pcl_cell.sv
// One storage cell of the list chain.
`default_nettype none
module pcl_cell #(
	parameter int IDX = 0
) (
	input  wire logic                      clk,
	input  wire pcl_pkg::cell_ctl_t        ctl,
	input  wire logic [pcl_pkg::DATA_W-1:0] left,
	input  wire logic [pcl_pkg::DATA_W-1:0] right,
	input  wire logic [pcl_pkg::DATA_W-1:0] head,
	output logic      [pcl_pkg::DATA_W-1:0] data
);
	localparam logic [pcl_pkg::CNT_W-1:0] MY_IDX = pcl_pkg::CNT_W'(IDX);

	logic [pcl_pkg::DATA_W-1:0] data_q;
	logic [pcl_pkg::DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctl.act)
			pcl_pkg::ACT_HOLD: data_d = data_q;
			pcl_pkg::ACT_INS: begin
				if (MY_IDX > ctl.pos) data_d = left;
				else if (MY_IDX == ctl.pos) data_d = ctl.din;
			end
			pcl_pkg::ACT_DEL: begin
				if (MY_IDX >= ctl.pos) data_d = right;
			end
			pcl_pkg::ACT_ROT: begin
				if (MY_IDX == ctl.pos) data_d = head;
				else if (MY_IDX < ctl.pos) data_d = right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
endmodule
`default_nettype wire

>>> hw/rtl/positional_char_list.sv
// Top level of the positional byte list: request decode, cell chain, result register.
//
//  channel   | handshake        | fields
//  ----------+------------------+-------------------------------------
//  request   | start / busy     | req_type[2:0] value[7:0] position[5:0]
//  result    | strobe (1 cycle) | ok element[7:0] last length[5:0]
//
// Edits shift all cells in parallel; the result appears in the cycle after accept,
// and a new request may follow in the very next cycle.
// A dump rotates the chain once per element with busy high, one result per cycle;
// the chain is back in order when busy drops; an empty list gives one refused result.
// Reset clears the count and control; cell contents are left as they are.
// Results cannot be stalled by the receiver.
`default_nettype none
module positional_char_list #(
	parameter int CAPACITY = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [2:0]                   req_type,
	input  wire logic [7:0]                   value,
	input  wire logic [pcl_pkg::POS_W-1:0]    position,
	output logic                              strobe,
	output logic                              ok,
	output logic      [7:0]                   element,
	output logic                              last,
	output logic      [5:0]                   length
);
	localparam int CW = pcl_pkg::CNT_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              dix_q;
	logic                       strobe_q;
	logic                       ok_q;
	logic [pcl_pkg::DATA_W-1:0] element_q;
	logic                       last_q;
	logic [5:0]                 length_q;

	logic [pcl_pkg::DATA_W-1:0] data [CAPACITY];
	pcl_pkg::cell_ctl_t         ctl;

	logic          accept;
	logic [CW-1:0] pos_ext;
	logic [CW-1:0] cnt_m1;
	logic          edit_ok;
	logic [CW-1:0] cnt_d;

	assign accept  = start && (state_q == ST_IDLE);
	assign pos_ext = {1'b0, position};
	assign cnt_m1  = cnt_q - ONE_C;

	always_comb begin
		ctl.act = pcl_pkg::ACT_HOLD;
		ctl.pos = '0;
		ctl.din = value;
		edit_ok = 1'b0;
		cnt_d   = cnt_q;
		if (state_q == ST_DUMP) begin
			ctl.act = pcl_pkg::ACT_ROT;
			ctl.pos = cnt_m1;
		end else if (accept) begin
			unique case (req_type)
				pcl_pkg::REQ_INS_FRONT: begin
					ctl.pos = '0;
					edit_ok = cnt_q < CAP_C;
				end
				pcl_pkg::REQ_INS_POS: begin
					ctl.pos = pos_ext;
					edit_ok = (cnt_q < CAP_C) && ((pos_ext == '0) || (pos_ext < cnt_q));
				end
				pcl_pkg::REQ_INS_BACK: begin
					ctl.pos = cnt_q;
					edit_ok = cnt_q < CAP_C;
				end
				pcl_pkg::REQ_DEL_FRONT: begin
					ctl.pos = '0;
					edit_ok = cnt_q != '0;
				end
				pcl_pkg::REQ_DEL_POS: begin
					ctl.pos = pos_ext;
					edit_ok = pos_ext < cnt_q;
				end
				pcl_pkg::REQ_DEL_BACK: begin
					ctl.pos = cnt_m1;
					edit_ok = cnt_q != '0;
				end
				default: edit_ok = 1'b0;
			endcase
			if (edit_ok) begin
				if (req_type == pcl_pkg::REQ_INS_FRONT || req_type == pcl_pkg::REQ_INS_POS
					|| req_type == pcl_pkg::REQ_INS_BACK) begin
					ctl.act = pcl_pkg::ACT_INS;
					cnt_d   = cnt_q + ONE_C;
				end else begin
					ctl.act = pcl_pkg::ACT_DEL;
					cnt_d   = cnt_m1;
				end
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [pcl_pkg::DATA_W-1:0] left_w;
		logic [pcl_pkg::DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = data[i+1];
		end
		pcl_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.left (left_w),
			.right(right_w),
			.head (data[0]),
			.data (data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			dix_q     <= '0;
			strobe_q  <= 1'b0;
			ok_q      <= 1'b0;
			element_q <= '0;
			last_q    <= 1'b0;
			length_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == pcl_pkg::REQ_DUMP && cnt_q != '0) begin
							state_q <= ST_DUMP;
							dix_q   <= '0;
						end else begin
							strobe_q  <= 1'b1;
							ok_q      <= edit_ok;
							element_q <= '0;
							last_q    <= 1'b1;
							length_q  <= cnt_d[5:0];
							cnt_q     <= cnt_d;
						end
					end
				end
				ST_DUMP: begin
					strobe_q  <= 1'b1;
					ok_q      <= 1'b1;
					element_q <= data[0];
					last_q    <= dix_q == cnt_m1;
					length_q  <= cnt_q[5:0];
					dix_q     <= dix_q + ONE_C;
					if (dix_q == cnt_m1) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy    = state_q == ST_DUMP;
	assign strobe  = strobe_q;
	assign ok      = ok_q;
	assign element = element_q;
	assign last    = last_q;
	assign length  = length_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C) else $error("count above capacity");
	a_busy_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe) else $error("dump cycle without result");
	a_mid_dump: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy) else $error("non-last result outside dump");
	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> dix_q < cnt_q) else $error("dump index past count");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !ok |-> element == '0) else $error("failed result carries data");
endmodule
`default_nettype wire

>>> tb/tb_positional_char_list.sv
// Self-checking testbench for positional_char_list: edits, positional edge cases and dumps.
`timescale 1ns / 100ps
module tb_positional_char_list;
	localparam int LIST_CAP = 32;
	localparam int RANDOM_ITEMS = 240;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int TAIL_CYCLES = LIST_CAP + 8;
	localparam logic [pcl_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;

	typedef struct {
		bit       ok;
		bit [7:0] element;
		bit       last;
		bit [5:0] length;
	} list_beat_t;

	class pcl_tracker;
		int capacity;
		bit [7:0] shadow_cells[$];
		list_beat_t expected_beats[$];
		int errors;
		int n_requests;
		int n_dumps;
		int n_refused;
		int n_beats;
		int peak_length;

		function new(int capacity_i);
			capacity = capacity_i;
		endfunction

		function int depth();
			return shadow_cells.size();
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void push_beat(bit ok_b, bit [7:0] elem_b, bit last_b, int len_b);
			list_beat_t b;
			b.ok = ok_b;
			b.element = elem_b;
			b.last = last_b;
			b.length = len_b[5:0];
			expected_beats.push_back(b);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		function void take_request(logic [2:0] req, logic [7:0] val, logic [5:0] pos);
			bit done;
			int n;
			done = 1'b0;
			n = shadow_cells.size();
			n_requests++;
			case (req)
				pcl_pkg::REQ_INS_FRONT: if (n < capacity) begin
					shadow_cells.push_front(val);
					done = 1'b1;
				end
				pcl_pkg::REQ_INS_POS: if (n < capacity && (pos == 0 || pos < n)) begin
					shadow_cells.insert(pos, val);
					done = 1'b1;
				end
				pcl_pkg::REQ_INS_BACK: if (n < capacity) begin
					shadow_cells.push_back(val);
					done = 1'b1;
				end
				pcl_pkg::REQ_DEL_FRONT: if (n > 0) begin
					void'(shadow_cells.pop_front());
					done = 1'b1;
				end
				pcl_pkg::REQ_DEL_POS: if (pos < n) begin
					shadow_cells.delete(pos);
					done = 1'b1;
				end
				pcl_pkg::REQ_DEL_BACK: if (n > 0) begin
					void'(shadow_cells.pop_back());
					done = 1'b1;
				end
				pcl_pkg::REQ_DUMP: begin
					n_dumps++;
					if (n == 0) begin
						push_beat(1'b0, 8'd0, 1'b1, 0);
					end else begin
						for (int i = 0; i < n; i++)
							push_beat(1'b1, shadow_cells[i], i == n - 1, n);
					end
				end
				default: ;
			endcase
			if (req != pcl_pkg::REQ_DUMP) begin
				if (!done)
					n_refused++;
				push_beat(done, 8'd0, 1'b1, shadow_cells.size());
			end
			if (shadow_cells.size() > peak_length)
				peak_length = shadow_cells.size();
		endfunction

		function void check_beat(logic ok_a, logic [7:0] elem_a, logic last_a, logic [5:0] len_a);
			list_beat_t e;
			n_beats++;
			if (expected_beats.size() == 0) begin
				flag($sformatf("unexpected beat ok=%b element=%02h last=%b length=%0d",
					ok_a, elem_a, last_a, len_a));
				return;
			end
			e = expected_beats.pop_front();
			if (ok_a !== e.ok || elem_a !== e.element || last_a !== e.last || len_a !== e.length)
				flag($sformatf({"exp ok=%b element=%02h last=%b length=%0d, ",
					"got ok=%b element=%02h last=%b length=%0d"},
					e.ok, e.element, e.last, e.length, ok_a, elem_a, last_a, len_a));
		endfunction

		function void close();
			if (expected_beats.size() != 0)
				flag($sformatf("%0d expected beats never arrived", expected_beats.size()));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] req_type = '0;
	logic [7:0] value = '0;
	logic [5:0] position = '0;
	logic       busy;
	logic       strobe;
	logic       ok;
	logic [7:0] element;
	logic       last;
	logic [5:0] length;

	pcl_tracker tracker = new(LIST_CAP);
	int idle_cycles = 0;

	positional_char_list #(
		.CAPACITY(LIST_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.position(position),
		.strobe(strobe),
		.ok(ok),
		.element(element),
		.last(last),
		.length(length)
	);

	always #10 clk = ~clk;

	// check results first, then note the request accepted at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				tracker.check_beat(ok, element, last, length);
			if (start && !busy)
				tracker.take_request(req_type, value, position);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("positional_char_list regression: fail");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [2:0] req, input logic [7:0] val,
		input logic [5:0] pos);
		req_type <= req;
		value <= val;
		position <= pos;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
	endtask

	task automatic pick_request(input bit grow, output logic [2:0] req,
		output logic [7:0] val, output logic [5:0] pos);
		int roll;
		int n;
		roll = $urandom_range(0, 99);
		n = tracker.depth();
		if (grow) begin
			if (roll < 22) req = pcl_pkg::REQ_INS_FRONT;
			else if (roll < 44) req = pcl_pkg::REQ_INS_POS;
			else if (roll < 62) req = pcl_pkg::REQ_INS_BACK;
			else if (roll < 70) req = pcl_pkg::REQ_DEL_FRONT;
			else if (roll < 77) req = pcl_pkg::REQ_DEL_POS;
			else if (roll < 83) req = pcl_pkg::REQ_DEL_BACK;
			else if (roll < 96) req = pcl_pkg::REQ_DUMP;
			else req = REQ_UNUSED;
		end else begin
			if (roll < 6) req = pcl_pkg::REQ_INS_FRONT;
			else if (roll < 12) req = pcl_pkg::REQ_INS_POS;
			else if (roll < 17) req = pcl_pkg::REQ_INS_BACK;
			else if (roll < 37) req = pcl_pkg::REQ_DEL_FRONT;
			else if (roll < 62) req = pcl_pkg::REQ_DEL_POS;
			else if (roll < 82) req = pcl_pkg::REQ_DEL_BACK;
			else if (roll < 96) req = pcl_pkg::REQ_DUMP;
			else req = REQ_UNUSED;
		end
		val = $urandom_range(0, 255);
		if ($urandom_range(0, 4) == 0)
			pos = $urandom_range(0, 63);
		else
			pos = $urandom_range(0, n);
	endtask

	initial begin
		logic [2:0] r_req;
		logic [7:0] r_val;
		logic [5:0] r_pos;
		bit grow;
		int burst;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, refused edits, positional boundaries, single-element delete back
		send_request(pcl_pkg::REQ_DUMP, 8'h00, 6'd0);
		send_request(pcl_pkg::REQ_DEL_FRONT, 8'h00, 6'd0);
		send_request(pcl_pkg::REQ_DEL_POS, 8'h00, 6'd0);
		send_request(pcl_pkg::REQ_DEL_BACK, 8'h00, 6'd0);
		send_request(REQ_UNUSED, 8'hFF, 6'd63);
		send_request(pcl_pkg::REQ_INS_POS, 8'h11, 6'd5);
		send_request(pcl_pkg::REQ_INS_POS, 8'h5A, 6'd0);
		send_request(pcl_pkg::REQ_INS_FRONT, 8'hFF, 6'd0);
		send_request(pcl_pkg::REQ_INS_BACK, 8'h00, 6'd63);
		send_request(pcl_pkg::REQ_INS_POS, 8'hA5, 6'd1);
		send_request(pcl_pkg::REQ_INS_POS, 8'h3C, 6'd63);
		send_request(pcl_pkg::REQ_INS_POS, 8'hC3, 6'd4);
		send_request(pcl_pkg::REQ_DEL_POS, 8'h00, 6'd63);
		send_request(pcl_pkg::REQ_DEL_POS, 8'h00, 6'd4);
		send_request(pcl_pkg::REQ_DUMP, 8'h00, 6'd0);
		send_request(pcl_pkg::REQ_DEL_POS, 8'h00, 6'd3);
		send_request(pcl_pkg::REQ_DEL_BACK, 8'h00, 6'd0);
		send_request(pcl_pkg::REQ_DEL_FRONT, 8'h00, 6'd0);
		send_request(pcl_pkg::REQ_DUMP, 8'h00, 6'd0);
		send_request(pcl_pkg::REQ_DEL_BACK, 8'h00, 6'd0);
		send_request(pcl_pkg::REQ_DUMP, 8'h00, 6'd0);
		send_request(REQ_UNUSED, 8'h00, 6'd0);
		drain();

		grow = 1'b1;
		burst = 0;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (grow && tracker.depth() >= LIST_CAP && $urandom_range(0, 3) == 0)
				grow = 1'b0;
			else if (!grow && tracker.depth() == 0 && $urandom_range(0, 2) == 0)
				grow = 1'b1;
			if (k == RANDOM_ITEMS / 2)
				drain();
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				if ($urandom_range(0, 3) != 0)
					idle_sender($urandom_range(1, 6));
			end
			pick_request(grow, r_req, r_val, r_pos);
			send_request(r_req, r_val, r_pos);
			burst--;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		tracker.close();
		$display("Covered %0d requests (%0d dumps, %0d refused edits), %0d result beats checked,",
			tracker.n_requests, tracker.n_dumps, tracker.n_refused, tracker.n_beats);
		$display("peak list length %0d of %0d, %0d mismatches.",
			tracker.peak_length, LIST_CAP, tracker.errors);
		if (tracker.errors == 0)
			$display("positional_char_list regression: pass");
		else
			$display("positional_char_list regression: fail");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_cell.sv
hw/rtl/positional_char_list.sv
tb/tb_positional_char_list.sv
